### rtl/core/e2e_pkg.sv
package e2e_pkg;

    localparam int CORDIC_STAGES = 30;
    localparam int VECTOR_BITS   = 40;

    localparam int ANG_BITS  = 32;
    localparam int CRD_BITS  = 34;
    localparam int Q_BITS    = 32;
    localparam int OUT_BITS  = VECTOR_BITS + 1;
    localparam int EXT_BITS  = (VECTOR_BITS > 32) ? VECTOR_BITS : 32;
    localparam int HI_BITS   = EXT_BITS - 30;
    localparam int LOP_BITS  = 63;
    localparam int ACC_BITS  = 64;
    localparam int WIDE_BITS = 66;

    // cordic: input fold + stages + output clamp; then two coefficient stages
    localparam int PRE_DEPTH  = CORDIC_STAGES + 4;
    localparam int PIPE_DEPTH = PRE_DEPTH + 4;

    typedef logic signed [Q_BITS-1:0]    t_q30;
    typedef logic signed [CRD_BITS-1:0]  t_crd;
    typedef logic signed [ACC_BITS-1:0]  t_acc;
    typedef logic signed [WIDE_BITS-1:0] t_wide;

    localparam t_crd CORDIC_GAIN = 34'sd652032874;
    localparam t_crd Q30_ONE_C   = 34'sd1073741824;
    localparam t_acc Q30_HALF    = 64'sd536870912;
    localparam t_acc OUT_MAX     = (64'sd1 <<< VECTOR_BITS) - 64'sd1;
    localparam t_acc OUT_MIN     = -OUT_MAX - 64'sd1;
    localparam t_wide S64_MAX    = 66'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam t_wide S64_MIN    = -S64_MAX - 66'sd1;

    function automatic t_crd atan_bam(input int idx);
        t_crd v;
        case (idx)
            0:  v = 34'sh20000000;
            1:  v = 34'sh12E4051E;
            2:  v = 34'sh09FB385B;
            3:  v = 34'sh051111D4;
            4:  v = 34'sh028B0D43;
            5:  v = 34'sh0145D7E1;
            6:  v = 34'sh00A2F61E;
            7:  v = 34'sh00517C55;
            8:  v = 34'sh0028BE53;
            9:  v = 34'sh00145F2F;
            10: v = 34'sh000A2F98;
            11: v = 34'sh000517CC;
            12: v = 34'sh00028BE6;
            13: v = 34'sh000145F3;
            14: v = 34'sh0000A2FA;
            15: v = 34'sh0000517D;
            16: v = 34'sh000028BE;
            17: v = 34'sh0000145F;
            18: v = 34'sh00000A30;
            19: v = 34'sh00000518;
            20: v = 34'sh0000028C;
            21: v = 34'sh00000146;
            22: v = 34'sh000000A3;
            23: v = 34'sh00000051;
            24: v = 34'sh00000029;
            25: v = 34'sh00000014;
            26: v = 34'sh0000000A;
            27: v = 34'sh00000005;
            28: v = 34'sh00000003;
            29: v = 34'sh00000001;
            30: v = 34'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_q30 clamp_q30(input t_crd v);
        t_q30 r;
        if (v > Q30_ONE_C) begin
            r = Q_BITS'(Q30_ONE_C);
        end else if (v < -Q30_ONE_C) begin
            r = Q_BITS'(-Q30_ONE_C);
        end else begin
            r = Q_BITS'(v);
        end
        return r;
    endfunction

    function automatic t_acc sat64(input t_wide v);
        t_acc r;
        if (v > S64_MAX) begin
            r = ACC_BITS'(S64_MAX);
        end else if (v < S64_MIN) begin
            r = ACC_BITS'(S64_MIN);
        end else begin
            r = ACC_BITS'(v);
        end
        return r;
    endfunction

endpackage

### rtl/core/ecef_to_enu_rotation.sv
// ECEF to ENU vector rotation.
// Input channel: i_valid / o_ready, one beat carries latitude, longitude
// (32-bit binary angles, 2^31 = pi) and an Earth-centered vector x/y/z.
// Output channel: o_valid / i_ready, one beat of east/north/up per input
// beat, saturated to 41 bits, in input order.
// Pipeline: CORDIC_STAGES + 8 register stages: input fold, one register per
// CORDIC stage for both angles, clamp, two stages for the rotation
// coefficients, then four stages of products, sums, rounding and saturation.
// Throughput: one beat per cycle while not stalled; the whole pipeline
// advances as one.
// Stall: while o_valid is high and i_ready is low, every stage holds and
// o_ready drops; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits; the
// block keeps no state between beats.
module ecef_to_enu_rotation (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [31:0]                     i_latitude,
    input  logic signed [31:0]                     i_longitude,
    input  logic signed [e2e_pkg::VECTOR_BITS-1:0] i_vec_x,
    input  logic signed [e2e_pkg::VECTOR_BITS-1:0] i_vec_y,
    input  logic signed [e2e_pkg::VECTOR_BITS-1:0] i_vec_z,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [e2e_pkg::OUT_BITS-1:0]    o_east,
    output logic signed [e2e_pkg::OUT_BITS-1:0]    o_north,
    output logic signed [e2e_pkg::OUT_BITS-1:0]    o_up
);

    localparam int PRE = e2e_pkg::PRE_DEPTH;
    localparam int L   = e2e_pkg::PIPE_DEPTH;
    localparam int VB  = e2e_pkg::VECTOR_BITS;
    localparam int HB  = e2e_pkg::HI_BITS;

    logic w_en;
    logic [L-1:0] r_vld;

    e2e_pkg::t_q30 w_slat, w_clat, w_slon, w_clon;

    logic signed [VB-1:0] r_vec [0:PRE-1][0:2];

    e2e_pkg::t_q30 r_m_slat, r_m_clat, r_m_slon, r_m_clon;
    logic signed [63:0] r_p_sc, r_p_ss, r_p_cc, r_p_cs;
    e2e_pkg::t_q30 r_coef [0:8];

    logic signed [HB+31:0]                r_ph [0:8];
    logic signed [e2e_pkg::LOP_BITS-1:0]  r_pl [0:8];
    e2e_pkg::t_acc r_hi  [0:2];
    e2e_pkg::t_acc r_lo  [0:2];
    e2e_pkg::t_acc r_hi3 [0:2];
    e2e_pkg::t_acc r_lor [0:2];
    logic signed [e2e_pkg::OUT_BITS-1:0] r_out [0:2];

    e2e_pkg::t_acc n_fin [0:2];

    assign w_en    = i_ready || !r_vld[L-1];
    assign o_ready = w_en;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    e2e_cordic u_lat (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_latitude),
        .o_sin   (w_slat),
        .o_cos   (w_clat)
    );

    e2e_cordic u_lon (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_longitude),
        .o_sin   (w_slon),
        .o_cos   (w_clon)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vec[0][0] <= i_vec_x;
            r_vec[0][1] <= i_vec_y;
            r_vec[0][2] <= i_vec_z;
            for (int s = 1; s < PRE; s++) begin
                r_vec[s] <= r_vec[s-1];
            end
        end
    end

    // products of sines and cosines
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_slat <= w_slat;
            r_m_clat <= w_clat;
            r_m_slon <= w_slon;
            r_m_clon <= w_clon;
            r_p_sc   <= 64'(w_slat) * 64'(w_clon);
            r_p_ss   <= 64'(w_slat) * 64'(w_slon);
            r_p_cc   <= 64'(w_clat) * 64'(w_clon);
            r_p_cs   <= 64'(w_clat) * 64'(w_slon);
        end
    end

    function automatic e2e_pkg::t_q30 rnd30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + e2e_pkg::Q30_HALF) >>> 30;
        return e2e_pkg::Q_BITS'(t);
    endfunction

    // rotation rows: east, north, up
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_coef[0] <= -r_m_slon;
            r_coef[1] <= r_m_clon;
            r_coef[2] <= '0;
            r_coef[3] <= -rnd30(r_p_sc);
            r_coef[4] <= -rnd30(r_p_ss);
            r_coef[5] <= r_m_clat;
            r_coef[6] <= rnd30(r_p_cc);
            r_coef[7] <= rnd30(r_p_cs);
            r_coef[8] <= r_m_slat;
        end
    end

    // split each component into high part and low 30 bits
    always_ff @(posedge i_clk) begin
        logic signed [e2e_pkg::EXT_BITS-1:0] ext;
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    ext = e2e_pkg::EXT_BITS'(r_vec[PRE-1][k]);
                    r_ph[3*j+k] <= $signed(ext[e2e_pkg::EXT_BITS-1:30]) * r_coef[3*j+k];
                    r_pl[3*j+k] <= $signed({1'b0, ext[29:0]}) * r_coef[3*j+k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        e2e_pkg::t_acc s1;
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                s1 = e2e_pkg::sat64(e2e_pkg::WIDE_BITS'(r_ph[3*j])
                                  + e2e_pkg::WIDE_BITS'(r_ph[3*j+1]));
                r_hi[j] <= e2e_pkg::sat64(e2e_pkg::WIDE_BITS'(s1)
                                        + e2e_pkg::WIDE_BITS'(r_ph[3*j+2]));
                r_lo[j] <= e2e_pkg::ACC_BITS'(r_pl[3*j]) + e2e_pkg::ACC_BITS'(r_pl[3*j+1])
                         + e2e_pkg::ACC_BITS'(r_pl[3*j+2]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_hi3[j] <= r_hi[j];
                r_lor[j] <= (r_lo[j] + e2e_pkg::Q30_HALF) >>> 30;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_fin[j] = e2e_pkg::sat64(e2e_pkg::WIDE_BITS'(r_hi3[j])
                                    + e2e_pkg::WIDE_BITS'(r_lor[j]));
            if (n_fin[j] > e2e_pkg::OUT_MAX) begin
                n_fin[j] = e2e_pkg::OUT_MAX;
            end else if (n_fin[j] < e2e_pkg::OUT_MIN) begin
                n_fin[j] = e2e_pkg::OUT_MIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_out[j] <= e2e_pkg::OUT_BITS'(n_fin[j]);
            end
        end
    end

    assign o_east  = r_out[0];
    assign o_north = r_out[1];
    assign o_up    = r_out[2];

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_out[0]) && $stable(r_out[2])))
        else $error("stalled result changed");

endmodule

### rtl/core/e2e_cordic.sv
module e2e_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [e2e_pkg::ANG_BITS-1:0]        i_angle,
    output e2e_pkg::t_q30                       o_sin,
    output e2e_pkg::t_q30                       o_cos
);

    localparam int N = e2e_pkg::CORDIC_STAGES;

    e2e_pkg::t_crd r_x [0:N];
    e2e_pkg::t_crd r_y [0:N];
    e2e_pkg::t_crd r_z [0:N];
    logic          r_flip [0:N];
    e2e_pkg::t_q30 r_sin;
    e2e_pkg::t_q30 r_cos;

    logic                         w_flip;
    logic [e2e_pkg::ANG_BITS-1:0] w_fold;
    e2e_pkg::t_crd                n_cos;
    e2e_pkg::t_crd                n_sin;

    // fold into [-pi/2, pi/2) by adding pi
    assign w_flip = i_angle[e2e_pkg::ANG_BITS-1] ^ i_angle[e2e_pkg::ANG_BITS-2];
    assign w_fold = {i_angle[e2e_pkg::ANG_BITS-1] ^ w_flip, i_angle[e2e_pkg::ANG_BITS-2:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= e2e_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= e2e_pkg::CRD_BITS'($signed(w_fold));
            r_flip[0] <= w_flip;
            for (int k = 0; k < N; k++) begin
                r_flip[k+1] <= r_flip[k];
                if (!r_z[k][e2e_pkg::CRD_BITS-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - e2e_pkg::atan_bam(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + e2e_pkg::atan_bam(k);
                end
            end
        end
    end

    always_comb begin
        n_cos = r_flip[N] ? -r_x[N] : r_x[N];
        n_sin = r_flip[N] ? -r_y[N] : r_y[N];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= e2e_pkg::clamp_q30(n_cos);
            r_sin <= e2e_pkg::clamp_q30(n_sin);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

### test/ecef_to_enu_rotation_test.sv
`timescale 1ns / 100ps

module ecef_to_enu_rotation_test;

    localparam int VB = e2e_pkg::VECTOR_BITS;
    localparam int OB = e2e_pkg::OUT_BITS;
    localparam longint VMAX = (64'sd1 <<< (VB - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam longint LAT_HI = 64'sd1073741824;

    typedef struct {
        logic signed [31:0]   lat;
        logic signed [31:0]   lon;
        logic signed [VB-1:0] x;
        logic signed [VB-1:0] y;
        logic signed [VB-1:0] z;
    } t_beat_in;

    typedef struct {
        logic signed [OB-1:0] east;
        logic signed [OB-1:0] north;
        logic signed [OB-1:0] up;
    } t_enu;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic signed [31:0]   i_latitude = '0;
    logic signed [31:0]   i_longitude = '0;
    logic signed [VB-1:0] i_vec_x = '0;
    logic signed [VB-1:0] i_vec_y = '0;
    logic signed [VB-1:0] i_vec_z = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [OB-1:0] o_east;
    logic signed [OB-1:0] o_north;
    logic signed [OB-1:0] o_up;

    t_enu   enu_pending[$];
    int     errors = 0;
    bit     stim_done = 1'b0;
    bit     hold_off = 1'b0;

    ecef_to_enu_rotation DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        logic signed [64:0] w;
        w = 65'(a) + 65'(b);
        if (w > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (w < -65'sh0_7FFF_FFFF_FFFF_FFFF - 1) return 64'h8000_0000_0000_0000;
        return longint'(w);
    endfunction

    function automatic longint q30_clip(longint v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    function automatic void trig(logic [31:0] ang, output longint s, output longint c);
        logic [31:0] u;
        bit          flip;
        longint      x, y, z, dx, dy;
        u = ang;
        flip = (u[31] != u[30]);
        if (flip) u = u + 32'h8000_0000;
        z = longint'(signed'(u));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < e2e_pkg::CORDIC_STAGES; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(e2e_pkg::atan_bam(i));
            end else begin
                x += dx; y -= dy; z += longint'(e2e_pkg::atan_bam(i));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = q30_clip(x);
        s = q30_clip(y);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return floor_shr(a * b + 64'sd536870912, 30);
    endfunction

    function automatic logic signed [OB-1:0] project(longint r0, longint r1, longint r2,
                                                       longint v0, longint v1, longint v2);
        longint row[3], v[3], hi, lo, r, lim;
        row = '{r0, r1, r2};
        v = '{v0, v1, v2};
        hi = 0; lo = 0;
        lim = (64'sd1 <<< VB) - 1;
        for (int k = 0; k < 3; k++) begin
            hi = add_sat(hi, floor_shr(v[k], 30) * row[k]);
            lo += (v[k] & 64'h3FFF_FFFF) * row[k];
        end
        r = add_sat(hi, floor_shr(lo + 64'sd536870912, 30));
        if (r > lim) r = lim;
        if (r < -lim - 1) r = -lim - 1;
        return OB'(r);
    endfunction

    function automatic t_enu rotate_enu(t_beat_in b);
        longint sa, ca, so, co, x, y, z;
        t_enu   r;
        trig(b.lat, sa, ca);
        trig(b.lon, so, co);
        x = longint'(b.x); y = longint'(b.y); z = longint'(b.z);
        r.east  = project(-so, co, 0, x, y, z);
        r.north = project(-qmul(sa, co), -qmul(sa, so), ca, x, y, z);
        r.up    = project(qmul(ca, co), qmul(ca, so), sa, x, y, z);
        return r;
    endfunction

    task automatic send_beat(t_beat_in b);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
            : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_latitude  <= b.lat;
        i_longitude <= b.lon;
        i_vec_x     <= b.x;
        i_vec_y     <= b.y;
        i_vec_z     <= b.z;
        do @(posedge i_clk); while (!o_ready);
        enu_pending.push_back(rotate_enu(b));
        @(negedge i_clk);
    endtask

    function automatic logic signed [VB-1:0] rand_vec();
        case ($urandom_range(0, 5))
            0: return VB'(VMAX);
            1: return VB'(VMIN);
            2: return VB'($signed($urandom_range(0, 2000)) - 1000);
            default: return VB'({$urandom, $urandom});
        endcase
    endfunction

    initial begin
        t_beat_in b;
        t_beat_in dir_tbl[$];
        longint   lat_tbl[8];
        lat_tbl = '{0, LAT_HI, -LAT_HI, LAT_HI / 2, -LAT_HI / 2, 1, -1, 64'sh7FFF_FFFF};
        for (int i = 0; i < 8; i++) begin
            dir_tbl.push_back('{32'(lat_tbl[i]), 32'h8000_0000 + 32'(i) * 32'h2000_0000,
                                VB'(VMAX), VB'(VMIN), VB'(VMAX)});
        end
        dir_tbl.push_back('{32'h0, 32'h0, VB'(VMIN), VB'(VMIN), VB'(VMIN)});
        dir_tbl.push_back('{32'h0, 32'h0, VB'(VMAX), VB'(VMAX), VB'(VMAX)});
        dir_tbl.push_back('{32'h0, 32'h0, '0, '0, '0});
        dir_tbl.push_back('{32'h4000_0000, 32'h7FFF_FFFF, VB'(-1), VB'(1), VB'(-1)});
        dir_tbl.push_back('{32'h8000_0000, 32'h4000_0000, VB'(12345), VB'(-6789), VB'(42)});
        dir_tbl.push_back('{32'hC000_0000, 32'hC000_0000, VB'(VMAX), VB'(0), VB'(VMIN)});
        dir_tbl.push_back('{32'h2000_0000, 32'hFFFF_FFFF, VB'(VMIN), VB'(VMAX), VB'(0)});
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (dir_tbl[i]) send_beat(dir_tbl[i]);
        // directed case with a result readable at a glance
        send_beat('{32'h0, 32'h0, '0, '0, '0});
        for (int n = 0; n < 2000; n++) begin
            b.lat = ($urandom_range(0, 3) == 0) ? $urandom
                  : 32'($signed($urandom_range(0, 32'h8000_0000)) - LAT_HI);
            b.lon = $urandom;
            b.x = rand_vec();
            b.y = rand_vec();
            b.z = rand_vec();
            if (n == 500) hold_off = 1'b1;
            send_beat(b);
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(negedge i_clk) begin
        if (hold_off) begin
            i_ready <= 1'b0;
            repeat (200) @(negedge i_clk);
            hold_off = 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(5, 30)) @(negedge i_clk);
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0) || !i_rst_n ? i_rst_n : 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_enu e;
        if (i_rst_n && o_valid && i_ready) begin
            if (enu_pending.size() == 0) begin
                $display("%0t: unexpected beat east=%0d north=%0d up=%0d",
                         $time, o_east, o_north, o_up);
                errors++;
            end else begin
                e = enu_pending.pop_front();
                if (e.east !== o_east) begin
                    $display("%0t: east exp %0d got %0d", $time, e.east, o_east);
                    errors++;
                end
                if (e.north !== o_north) begin
                    $display("%0t: north exp %0d got %0d", $time, e.north, o_north);
                    errors++;
                end
                if (e.up !== o_up) begin
                    $display("%0t: up exp %0d got %0d", $time, e.up, o_up);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (enu_pending.size() == 0);
        repeat (2 * (e2e_pkg::CORDIC_STAGES + 8)) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
